[hdl/lpt_pkg.sv]
`timescale 1ns / 1ps

package lpt_pkg;

	localparam int TIME_W  = 48;
	localparam int RATIO_W = 16;
	localparam int AVG_W   = 18;
	localparam int REG_W   = 20;
	localparam int IDX_W   = 2;

	// reset values of the configuration registers
	localparam logic [REG_W-1:0] STALL_GAP_RST     = 20'd1000;
	localparam logic [REG_W-1:0] RECOVERY_HOLD_RST = 20'd5000;
	localparam logic [REG_W-1:0] MIN_DWELL_RST     = 20'd2000;

	// entry thresholds in Q2.16 (Q2.14 values scaled by 4)
	localparam logic [AVG_W-1:0] MEM_CRIT = 18'(4 * 15565);
	localparam logic [AVG_W-1:0] MEM_HIGH = 18'(4 * 14746);
	localparam logic [AVG_W-1:0] MEM_ELEV = 18'(4 * 13107);
	localparam logic [AVG_W-1:0] REN_CRIT = 18'(4 * 15565);
	localparam logic [AVG_W-1:0] REN_HIGH = 18'(4 * 13107);
	localparam logic [AVG_W-1:0] REN_ELEV = 18'(4 * 10650);

	// lag thresholds stay in Q2.14
	localparam logic [RATIO_W-1:0] LAG_CRIT = 16'd819;
	localparam logic [RATIO_W-1:0] LAG_HIGH = 16'd328;

	typedef enum logic [1:0] {
		LVL_NORMAL   = 2'd0,
		LVL_ELEVATED = 2'd1,
		LVL_HIGH     = 2'd2,
		LVL_CRITICAL = 2'd3
	} level_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_STALL_GAP     = 2'd0,
		CFG_RECOVERY_HOLD = 2'd1,
		CFG_MIN_DWELL     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  time_ms;
		logic               memory_ok;
		logic [RATIO_W-1:0] mem_frac;
		logic               render_ok;
		logic [RATIO_W-1:0] ren_frac;
		logic               lag_ok;
		logic [RATIO_W-1:0] lag_frac;
	} sample_t;

	typedef struct packed {
		logic [REG_W-1:0] stall_gap_ms;
		logic [REG_W-1:0] recovery_hold_ms;
		logic [REG_W-1:0] min_dwell_ms;
	} cfg_regs_t;

	// exit thresholds for the memory average, Q2.16
	function automatic logic [AVG_W-1:0] mem_exit(input level_t lvl);
		logic [AVG_W-1:0] v;
		unique case (lvl)
			LVL_NORMAL:   v = '0;
			LVL_ELEVATED: v = 18'(4 * 12288);
			LVL_HIGH:     v = 18'(4 * 13926);
			LVL_CRITICAL: v = 18'(4 * 14746);
		endcase
		return v;
	endfunction

	// exit thresholds for the render average, Q2.16
	function automatic logic [AVG_W-1:0] ren_exit(input level_t lvl);
		logic [AVG_W-1:0] v;
		unique case (lvl)
			LVL_NORMAL:   v = '0;
			LVL_ELEVATED: v = 18'(4 * 9011);
			LVL_HIGH:     v = 18'(4 * 11469);
			LVL_CRITICAL: v = 18'(4 * 13926);
		endcase
		return v;
	endfunction

endpackage

[hdl/lpt_avg.sv]
`timescale 1ns / 1ps

module lpt_avg (
	input  logic                   ok,
	input  logic                   primed,
	input  logic [lpt_pkg::AVG_W-1:0]   avg,
	input  logic [lpt_pkg::RATIO_W-1:0] ratio,
	output logic [lpt_pkg::AVG_W-1:0]   avg_next
);
	import lpt_pkg::*;

	logic [AVG_W-1:0] x;
	logic [AVG_W+1:0] sum;

	// ratio to Q2.16, then 3/4 old plus 1/4 new
	assign x   = {ratio, 2'b00};
	assign sum = {1'b0, avg, 1'b0} + {2'b00, avg} + {2'b00, x};

	always_comb begin
		if (!ok) begin
			avg_next = '0;
		end else if (!primed) begin
			avg_next = x;
		end else begin
			avg_next = sum[AVG_W+1:2];
		end
	end

endmodule

[hdl/lpt_core.sv]
`timescale 1ns / 1ps

module lpt_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  lpt_pkg::sample_t   sample,
	input  lpt_pkg::cfg_regs_t cfg,
	output lpt_pkg::level_t    level_next
);
	import lpt_pkg::*;

	logic [AVG_W-1:0]  memory_avg_q, render_avg_q;
	logic              primed_q, in_recovery_q;
	level_t            level_q;
	logic [TIME_W-1:0] last_time_q, change_time_q, recovery_start_q;

	logic [AVG_W-1:0]  mem_avg_d, ren_avg_d;
	logic              primed_d, in_recovery_d;
	level_t            level_d;
	logic [TIME_W-1:0] last_time_d, change_time_d, recovery_start_d;

	logic [TIME_W:0]   gap_diff, hold_diff, dwell_diff;
	logic              gap_cancel, held, dwelt, exit_clear, rec_live;
	logic [RATIO_W-1:0] lag;
	level_t            target;
	logic [AVG_W-1:0]  mem_new, ren_new;

	// running averages
	lpt_avg u_mem_avg (
		.ok       (sample.memory_ok),
		.primed   (primed_q),
		.avg      (memory_avg_q),
		.ratio    (sample.mem_frac),
		.avg_next (mem_new)
	);

	lpt_avg u_ren_avg (
		.ok       (sample.render_ok),
		.primed   (primed_q),
		.avg      (render_avg_q),
		.ratio    (sample.ren_frac),
		.avg_next (ren_new)
	);

	// time differences, top bit is the borrow
	assign gap_diff   = {1'b0, sample.time_ms} - {1'b0, last_time_q};
	assign hold_diff  = {1'b0, sample.time_ms} - {1'b0, recovery_start_q};
	assign dwell_diff = {1'b0, sample.time_ms} - {1'b0, change_time_q};

	assign gap_cancel = primed_q && (gap_diff[TIME_W] ||
		(gap_diff[TIME_W-1:0] > {{(TIME_W-REG_W){1'b0}}, cfg.stall_gap_ms}));
	assign held  = !hold_diff[TIME_W] &&
		(hold_diff[TIME_W-1:0] >= {{(TIME_W-REG_W){1'b0}}, cfg.recovery_hold_ms});
	assign dwelt = !dwell_diff[TIME_W] &&
		(dwell_diff[TIME_W-1:0] >= {{(TIME_W-REG_W){1'b0}}, cfg.min_dwell_ms});
	assign rec_live = in_recovery_q && !gap_cancel;

	// lag counts only with a valid render ratio
	assign lag = (sample.render_ok && sample.lag_ok) ? sample.lag_frac : '0;

	// level called for by the entry thresholds
	always_comb begin
		priority if (mem_new >= MEM_CRIT || ren_new >= REN_CRIT || lag >= LAG_CRIT) begin
			target = LVL_CRITICAL;
		end else if (mem_new >= MEM_HIGH || ren_new >= REN_HIGH || lag >= LAG_HIGH) begin
			target = LVL_HIGH;
		end else if (mem_new >= MEM_ELEV || ren_new >= REN_ELEV || lag != '0) begin
			target = LVL_ELEVATED;
		end else begin
			target = LVL_NORMAL;
		end
	end

	assign exit_clear = (mem_new < mem_exit(level_q)) && (ren_new < ren_exit(level_q)) &&
		(lag == '0);

	// next state
	always_comb begin
		mem_avg_d        = mem_new;
		ren_avg_d        = ren_new;
		primed_d         = 1'b1;
		last_time_d      = sample.time_ms;
		level_d          = level_q;
		change_time_d    = change_time_q;
		recovery_start_d = recovery_start_q;
		in_recovery_d    = 1'b0;
		if (!sample.memory_ok && !sample.render_ok) begin
			mem_avg_d        = '0;
			ren_avg_d        = '0;
			primed_d         = 1'b0;
			last_time_d      = '0;
			level_d          = LVL_NORMAL;
			change_time_d    = '0;
			recovery_start_d = '0;
		end else if (target > level_q) begin
			level_d       = target;
			change_time_d = sample.time_ms;
		end else if (target < level_q) begin
			if (exit_clear) begin
				if (!rec_live) begin
					in_recovery_d    = 1'b1;
					recovery_start_d = sample.time_ms;
				end else if (held && dwelt) begin
					level_d       = level_t'(level_q - 2'd1);
					change_time_d = sample.time_ms;
				end else begin
					in_recovery_d = 1'b1;
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_avg_q     <= '0;
			render_avg_q     <= '0;
			primed_q         <= 1'b0;
			level_q          <= LVL_NORMAL;
			in_recovery_q    <= 1'b0;
			last_time_q      <= '0;
			change_time_q    <= '0;
			recovery_start_q <= '0;
		end else if (step) begin
			memory_avg_q     <= mem_avg_d;
			render_avg_q     <= ren_avg_d;
			primed_q         <= primed_d;
			level_q          <= level_d;
			in_recovery_q    <= in_recovery_d;
			last_time_q      <= last_time_d;
			change_time_q    <= change_time_d;
			recovery_start_q <= recovery_start_d;
		end
	end

	assign level_next = level_d;

endmodule

[hdl/load_pressure_level_tracker_unit.sv]
`timescale 1ns / 1ps

// Load pressure level tracker.
// s_axis carries one sample word a cycle while ready: tdata holds time_ms and
// the memory, render and lag ratios; tuser holds the three valid flags.
// m_axis returns one word per sample with the pressure level (0 normal up to
// 3 critical) in tdata bits [1:0].
// cfg_valid/cfg_ready write stall_gap_ms (index 0), recovery_hold_ms (1) and
// min_dwell_ms (2); other indexes are ignored. Write only while idle.
// A sample accepted into the input register has its result registered in the
// result register once that register is free. Throughput is one sample per
// cycle while m_axis_tready is high, as the averages and level state update
// combinationally between the input and result registers.
// Reset clears averages, level, timestamps, empties both pipeline registers
// and loads the register defaults 1000, 5000 and 2000 ms.
// When m_axis_tready is low the result word holds, one more sample waits in
// the input register, and s_axis_tready drops until the result is taken.
module load_pressure_level_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// time_ms[47:0], mem_frac[63:48], ren_frac[79:64], lag_frac[95:80]
	input  logic [95:0] s_axis_tdata,
	// memory_ok[0], render_ok[1], lag_ok[2]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pressure_level[1:0], zero fill above
	output logic [7:0]  m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import lpt_pkg::*;

	cfg_regs_t cfg_q;
	sample_t   sample_s1;
	logic      valid_s1;
	logic      advance;
	logic      out_valid_q;
	level_t    out_level_q;
	level_t    level_next;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_gap_ms     <= STALL_GAP_RST;
			cfg_q.recovery_hold_ms <= RECOVERY_HOLD_RST;
			cfg_q.min_dwell_ms     <= MIN_DWELL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_STALL_GAP:     cfg_q.stall_gap_ms     <= cfg_data;
				CFG_RECOVERY_HOLD: cfg_q.recovery_hold_ms <= cfg_data;
				CFG_MIN_DWELL:     cfg_q.min_dwell_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: sample moves to the result register when it is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1.time_ms   <= s_axis_tdata[47:0];
			sample_s1.mem_frac  <= s_axis_tdata[63:48];
			sample_s1.ren_frac  <= s_axis_tdata[79:64];
			sample_s1.lag_frac  <= s_axis_tdata[95:80];
			sample_s1.memory_ok <= s_axis_tuser[0];
			sample_s1.render_ok <= s_axis_tuser[1];
			sample_s1.lag_ok    <= s_axis_tuser[2];
		end
	end

	// averages and level state
	lpt_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.sample     (sample_s1),
		.cfg        (cfg_q),
		.level_next (level_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_level_q <= LVL_NORMAL;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			out_level_q <= level_next;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_level_q};

endmodule

[bench/pressure_level_checker.sv]
`timescale 1ns / 1ps

module pressure_level_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	input  logic        s_ready,
	// time_ms[47:0], mem_frac[63:48], ren_frac[79:64], lag_frac[95:80]
	input  logic [95:0] s_data,
	// memory_ok[0], render_ok[1], lag_ok[2]
	input  logic [2:0]  s_flags,
	input  logic        m_valid,
	input  logic        m_ready,
	// pressure_level[1:0], zero fill above
	input  logic [7:0]  m_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output int          mismatches,
	output int          pending,
	output int          results_checked,
	output int          step_downs,
	output int          critical_entries
);

	import lpt_pkg::*;

	// entry thresholds, Q2.16
	localparam logic [17:0] MEM_CRIT_Q16 = 18'd62260;
	localparam logic [17:0] MEM_HIGH_Q16 = 18'd58984;
	localparam logic [17:0] MEM_ELEV_Q16 = 18'd52428;
	localparam logic [17:0] REN_CRIT_Q16 = 18'd62260;
	localparam logic [17:0] REN_HIGH_Q16 = 18'd52428;
	localparam logic [17:0] REN_ELEV_Q16 = 18'd42600;
	// lag thresholds, Q2.14
	localparam logic [15:0] LAG_CRIT_Q14 = 16'd819;
	localparam logic [15:0] LAG_HIGH_Q14 = 16'd328;
	// register values after reset
	localparam logic [19:0] GAP_DEFAULT   = 20'd1000;
	localparam logic [19:0] HOLD_DEFAULT  = 20'd5000;
	localparam logic [19:0] DWELL_DEFAULT = 20'd2000;

	// register copies
	logic [19:0] stall_gap;
	logic [19:0] hold_span;
	logic [19:0] dwell_span;

	// tracker state
	logic [17:0] mem_avg;
	logic [17:0] ren_avg;
	logic        primed;
	level_t      level_now;
	logic        recovering;
	logic [47:0] prev_ms;
	logic [47:0] step_stamp;
	logic [47:0] calm_stamp;

	level_t expected_levels[$];

	function automatic logic [17:0] mem_exit_q16(input level_t lvl);
		case (lvl)
			LVL_ELEVATED: return 18'd49152;
			LVL_HIGH:     return 18'd55704;
			LVL_CRITICAL: return 18'd58984;
			default:      return 18'd0;
		endcase
	endfunction

	function automatic logic [17:0] ren_exit_q16(input level_t lvl);
		case (lvl)
			LVL_ELEVATED: return 18'd36044;
			LVL_HIGH:     return 18'd45876;
			LVL_CRITICAL: return 18'd55704;
			default:      return 18'd0;
		endcase
	endfunction

	// first word loads the average, later words move it by a quarter
	function automatic logic [17:0] blend(input logic [17:0] avg, input logic [15:0] ratio,
		input logic warm);
		logic [20:0] sum;
		sum = 21'(avg) * 21'd3 + 21'({ratio, 2'b00});
		return warm ? sum[19:2] : {ratio, 2'b00};
	endfunction

	function automatic logic span_passed(input logic [47:0] now, input logic [47:0] start,
		input logic [19:0] span);
		return now >= start && (now - start) >= {28'd0, span};
	endfunction

	task automatic clear_tracker();
		mem_avg    = '0;
		ren_avg    = '0;
		primed     = 1'b0;
		level_now  = LVL_NORMAL;
		recovering = 1'b0;
		prev_ms    = '0;
		step_stamp = '0;
		calm_stamp = '0;
	endtask

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	// level the block should report for one sample word
	task automatic track_sample(input logic [95:0] word, input logic [2:0] flags,
		output level_t result);
		logic [47:0] now;
		logic [15:0] lag;
		logic        mem_ok;
		logic        ren_ok;
		logic        calm;
		level_t      goal;
		now    = word[47:0];
		mem_ok = flags[0];
		ren_ok = flags[1];
		if (!mem_ok && !ren_ok) begin
			clear_tracker();
		end else begin
			// backward time or long gap kills a running recovery
			if (primed && (now < prev_ms || now - prev_ms > {28'd0, stall_gap}))
				recovering = 1'b0;
			prev_ms = now;
			mem_avg = mem_ok ? blend(mem_avg, word[63:48], primed) : '0;
			ren_avg = ren_ok ? blend(ren_avg, word[79:64], primed) : '0;
			primed  = 1'b1;
			lag     = (ren_ok && flags[2]) ? word[95:80] : '0;

			if (mem_avg >= MEM_CRIT_Q16 || ren_avg >= REN_CRIT_Q16 || lag >= LAG_CRIT_Q14)
				goal = LVL_CRITICAL;
			else if (mem_avg >= MEM_HIGH_Q16 || ren_avg >= REN_HIGH_Q16 || lag >= LAG_HIGH_Q14)
				goal = LVL_HIGH;
			else if (mem_avg >= MEM_ELEV_Q16 || ren_avg >= REN_ELEV_Q16 || lag != 16'd0)
				goal = LVL_ELEVATED;
			else
				goal = LVL_NORMAL;

			// rise at once, fall one step after hold and dwell
			if (goal > level_now) begin
				level_now  = goal;
				step_stamp = now;
				recovering = 1'b0;
				if (goal == LVL_CRITICAL)
					critical_entries++;
			end else if (goal < level_now) begin
				calm = mem_avg < mem_exit_q16(level_now) && ren_avg < ren_exit_q16(level_now)
					&& lag == 16'd0;
				if (!calm) begin
					recovering = 1'b0;
				end else if (!recovering) begin
					recovering = 1'b1;
					calm_stamp = now;
				end else if (span_passed(now, calm_stamp, hold_span)
					&& span_passed(now, step_stamp, dwell_span)) begin
					level_now  = level_t'(level_now - 2'd1);
					step_stamp = now;
					recovering = 1'b0;
					step_downs++;
				end
			end else begin
				recovering = 1'b0;
			end
		end
		result = level_now;
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		level_t lvl_next;
		level_t want;
		if (!arst_n) begin
			clear_tracker();
			stall_gap  = GAP_DEFAULT;
			hold_span  = HOLD_DEFAULT;
			dwell_span = DWELL_DEFAULT;
			expected_levels.delete();
			mismatches       = 0;
			results_checked  = 0;
			step_downs       = 0;
			critical_entries = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STALL_GAP:     stall_gap  = cfg_data;
					CFG_RECOVERY_HOLD: hold_span  = cfg_data;
					CFG_MIN_DWELL:     dwell_span = cfg_data;
					default: ;
				endcase
			end
			// result word against the oldest expectation
			if (m_valid && m_ready) begin
				if (expected_levels.size() == 0) begin
					report_mismatch("unexpected level word", 0, m_data[1:0]);
				end else begin
					want = expected_levels.pop_front();
					if (m_data[1:0] != want)
						report_mismatch("pressure_level", want, m_data[1:0]);
					results_checked++;
				end
			end
			// sample word in
			if (s_valid && s_ready) begin
				track_sample(s_data, s_flags, lvl_next);
				expected_levels.push_back(lvl_next);
			end
		end
		pending <= expected_levels.size();
	end

endmodule

[bench/load_pressure_level_tracker_unit_tb.sv]
`timescale 1ns / 1ps

module load_pressure_level_tracker_unit_tb;

	import lpt_pkg::*;

	localparam int          PHASES           = 10;
	localparam int          ITEMS_PER_PHASE  = 98;
	localparam int          LONG_HOLD_CYCLES = 200;
	localparam int          CYCLE_LIMIT      = 500000;
	// index that maps to no register
	localparam logic [1:0]  CFG_SPARE        = 2'd3;
	localparam logic [19:0] REG_MAX          = 20'hFFFFF;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata  = '0;
	logic [2:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [19:0] cfg_data      = '0;

	int mismatches;
	int pending;
	int results_checked;
	int step_downs;
	int critical_entries;

	int          cycle_count    = 0;
	int          samples_sent   = 0;
	int          settings_used  = 0;
	bit          send_idle_on   = 1'b1;
	bit          recv_idle_on   = 1'b1;
	bit          hold_req       = 1'b0;
	logic [47:0] t_now          = '0;
	logic [19:0] cur_gap        = 20'd1000;

	always #5 clk = ~clk;

	load_pressure_level_tracker_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	pressure_level_checker i_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_valid          (s_axis_tvalid),
		.s_ready          (s_axis_tready),
		.s_data           (s_axis_tdata),
		.s_flags          (s_axis_tuser),
		.m_valid          (m_axis_tvalid),
		.m_ready          (m_axis_tready),
		.m_data           (m_axis_tdata),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatches       (mismatches),
		.pending          (pending),
		.results_checked  (results_checked),
		.step_downs       (step_downs),
		.critical_entries (critical_entries)
	);

	// ratios sitting on or next to a threshold
	function automatic logic [15:0] edge_ratio();
		logic [15:0] base;
		case ($urandom_range(0, 8))
			0:       base = 16'd15565;
			1:       base = 16'd14746;
			2:       base = 16'd13107;
			3:       base = 16'd10650;
			4:       base = 16'd12288;
			5:       base = 16'd13926;
			6:       base = 16'd9011;
			7:       base = 16'd11469;
			default: base = 16'd0;
		endcase
		return base + 16'($urandom_range(0, 4)) - 16'd2;
	endfunction

	function automatic logic [15:0] hot_ratio();
		case ($urandom_range(0, 3))
			0:       return edge_ratio();
			3:       return 16'($urandom);
			default: return 16'($urandom_range(13000, 65535));
		endcase
	endfunction

	// low enough to clear every exit threshold once settled
	function automatic logic [15:0] calm_ratio();
		return 16'($urandom_range(0, 9000));
	endfunction

	function automatic logic [15:0] hot_lag();
		case ($urandom_range(0, 8))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'd327;
			3:       return 16'd328;
			4:       return 16'd329;
			5:       return 16'd818;
			6:       return 16'd819;
			7:       return 16'd820;
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one sample word, optionally after an idle burst
	task automatic offer_sample(input logic [47:0] ts, input logic mo, input logic [15:0] mr,
		input logic ro, input logic [15:0] rr, input logic lo, input logic [15:0] lr);
		if (send_idle_on && $urandom_range(0, 6) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {lr, rr, mr, ts};
		s_axis_tuser  <= {lo, ro, mo};
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
	endtask

	task automatic write_word(input logic [1:0] idx, input logic [19:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic [19:0] gap, input logic [19:0] hold,
		input logic [19:0] dwell, input bit touch_spare);
		if (touch_spare)
			write_word(CFG_SPARE, 20'($urandom));
		write_word(CFG_STALL_GAP, gap);
		write_word(CFG_RECOVERY_HOLD, hold);
		write_word(CFG_MIN_DWELL, dwell);
		cfg_valid <= 1'b0;
		cur_gap = gap;
		settings_used++;
	endtask

	// stop offering and wait out every outstanding level word
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	// load burst, then a calm stretch that should walk the level back down
	task automatic run_episode();
		int          k;
		int          hot_n;
		int          cool_n;
		logic        mo;
		logic        ro;
		logic        lo;
		logic [15:0] lr;
		hot_n  = $urandom_range(1, 5);
		cool_n = $urandom_range(6, 30);
		for (k = 0; k < hot_n; k++) begin
			t_now = t_now + 48'($urandom_range(0, 40));
			mo    = ($urandom_range(0, 7) != 0);
			ro    = ($urandom_range(0, 7) != 0);
			lo    = ($urandom_range(0, 3) != 0);
			offer_sample(t_now, mo, hot_ratio(), ro, hot_ratio(), lo, hot_lag());
		end
		for (k = 0; k < cool_n; k++) begin
			t_now = t_now + 48'($urandom_range(0, cur_gap));
			lo    = 1'($urandom_range(0, 1));
			if (lo)
				lr = ($urandom_range(0, 15) == 0) ? hot_lag() : 16'd0;
			else
				lr = 16'($urandom);
			// timing noise: backward step, stall, or a jump anywhere
			case ($urandom_range(0, 39))
				0:       t_now = t_now - 48'($urandom_range(1, 5000));
				1:       t_now = t_now + 48'(cur_gap) + 48'($urandom_range(1, 1000));
				2:       t_now = {16'($urandom), 32'($urandom)};
				default: ;
			endcase
			// content noise: clears, one side invalid, raw values
			case ($urandom_range(0, 29))
				0: offer_sample(t_now, 1'b0, 16'($urandom), 1'b0, 16'($urandom), lo, lr);
				1: offer_sample(t_now, 1'b1, 16'($urandom), 1'b1, 16'($urandom), lo, lr);
				2: offer_sample(t_now, 1'b0, 16'($urandom), 1'b1, calm_ratio(), lo, lr);
				3: offer_sample(t_now, 1'b1, calm_ratio(), 1'b0, 16'($urandom), lo, lr);
				default: offer_sample(t_now, 1'b1, calm_ratio(), 1'b1, calm_ratio(), lo, lr);
			endcase
		end
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				stall_left = LONG_HOLD_CYCLES - 1;
			end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(0, 17);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("load_pressure_level_tracker_unit verification failed");
			$finish;
		end
	end

	// stimulus and verdict
	initial begin
		int p;
		int phase_end;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		program_regs(20'd200, 20'd40, 20'd60, 1'b1);

		// directed: field extremes, recovery, cancel paths, invalid flags, clears
		offer_sample(48'd0, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd10, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
		offer_sample(48'd20, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd70, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd130, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd200, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd500, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd450, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd460, 1'b0, 16'hFFFF, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd470, 1'b1, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF);
		offer_sample(48'd480, 1'b1, 16'd0, 1'b1, 16'd0, 1'b0, 16'hFFFF);
		offer_sample(48'd490, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF);
		offer_sample(48'hFFFF_FFFF_FFFF, 1'b1, 16'd15565, 1'b1, 16'd0, 1'b1, 16'd0);
		offer_sample(48'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0);
		offer_sample(48'd100, 1'b1, 16'd14746, 1'b1, 16'd13107, 1'b1, 16'd0);
		offer_sample(48'd110, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0);
		offer_sample(48'd120, 1'b1, 16'd13107, 1'b1, 16'd10650, 1'b1, 16'd0);
		offer_sample(48'd130, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd819);
		offer_sample(48'd140, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd328);
		offer_sample(48'd150, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd1);
		offer_sample(48'd160, 1'b1, 16'd13106, 1'b1, 16'd15565, 1'b1, 16'd0);
		offer_sample(48'hAAAA_5555_AAAA, 1'b1, 16'h5555, 1'b1, 16'hAAAA, 1'b1, 16'h5555);
		settle();
		t_now = 48'd1000;

		// random phases over several register settings
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0:       program_regs(20'd200, 20'd40, 20'd60, 1'b0);
				1:       program_regs(20'd0, 20'd0, 20'd0, 1'b0);
				2:       program_regs(REG_MAX, REG_MAX, REG_MAX, 1'b0);
				3:       program_regs(20'd1000, 20'd5000, 20'd2000, 1'b1);
				4:       program_regs(20'd50, 20'd0, REG_MAX, 1'b0);
				5:       program_regs(REG_MAX, 20'd0, 20'd0, 1'b0);
				6:       program_regs(20'd300, REG_MAX, 20'd10, 1'b0);
				default: program_regs(20'($urandom_range(0, 2000)), 20'($urandom_range(0, 3000)),
					20'($urandom_range(0, 3000)), 1'b0);
			endcase
			// long output hold-off while samples keep coming
			if (p == 3)
				hold_req = 1'b1;
			if (p >= PHASES - 2) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end
			phase_end = samples_sent + ITEMS_PER_PHASE;
			while (samples_sent < phase_end)
				run_episode();
			settle();
		end

		$display("run covered %0d samples over %0d register settings, with idle bursts",
			samples_sent, settings_used);
		$display("%0d levels checked, %0d step-downs after recovery, %0d entries to critical",
			results_checked, step_downs, critical_entries);
		if (pending != 0)
			$display("%0d level words never arrived", pending);
		if (mismatches == 0 && pending == 0) begin
			$display("load_pressure_level_tracker_unit verification clean");
		end else begin
			$display("load_pressure_level_tracker_unit verification failed");
		end
		$finish;
	end

endmodule
